// ===== hdl/adll_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adll_pkg: shared types and constants of the array doubly linked list
// Slot store geometry, action and status codes, sequencer states.
// ---------------------------------------------------------------------------
package adll_pkg;

  localparam int Depth       = 16;
  localparam int IdxBits     = $clog2(Depth);
  localparam int LinkBits    = IdxBits + 1;
  localparam int PayloadBits = 64;

  // link value that means "no slot"
  localparam logic [LinkBits-1:0] NoneSlot = LinkBits'(Depth);

  typedef logic [IdxBits-1:0]     idx_t;
  typedef logic [LinkBits-1:0]    link_t;
  typedef logic [PayloadBits-1:0] payload_t;

  typedef enum logic [1:0] {
    ACT_HEAD  = 2'd0,
    ACT_AFTER = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_DONE   = 2'd0,
    STS_FULL   = 2'd1,
    STS_UNUSED = 2'd2,
    STS_RSVD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_LINK = 2'd2
  } state_t;

  // register indexes of the configuration port
  localparam logic [0:0] REG_SLOTS_IN_USE = 1'b0;

endpackage

// ===== hdl/adll_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adll_in_if / adll_out_if: valid/ready channels of the linked list
// Request channel carries the operation, the result channel its answer.
// ---------------------------------------------------------------------------
interface adll_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [3:0]          position;
  adll_pkg::payload_t  payload;

  modport source (output valid, action, position, payload, input ready);
  modport sink   (input valid, action, position, payload, output ready);
endinterface

interface adll_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [3:0]          slot_used;
  logic [4:0]          element_count;
  logic [4:0]          head_slot;
  logic [4:0]          tail_slot;
  adll_pkg::payload_t  read_payload;
  logic [4:0]          read_next;
  logic [4:0]          read_prev;

  modport source (output valid, status, slot_used, element_count, head_slot, tail_slot,
                  read_payload, read_next, read_prev, input ready);
  modport sink   (input valid, status, slot_used, element_count, head_slot, tail_slot,
                  read_payload, read_next, read_prev, output ready);
endinterface

// ===== hdl/array_doubly_linked_list.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// array_doubly_linked_list: doubly linked list in a 16-slot store
// Inserts at head or after a slot, or reads a slot with its links.
//
//   channel   dir  handshake             contents
//   in_ch     in   valid/ready           action, position, payload
//   out_ch    out  valid/ready           status, slot, count, head, tail, read data
//   apb       in   psel/penable/pready   slots_in_use (byte address 0)
//
// One item at a time: a read or rejected item passes from transfer through the
// memory read to its result; an insert goes through memory read, first link
// writes and second link writes, set by the single write port of each link
// memory. A new item is taken once the previous result has been transferred.
// Reset clears the busy map, head, tail and count and sets the capacity to 16;
// the memories are not cleared. A stalled result holds in the output register.
// ---------------------------------------------------------------------------
module array_doubly_linked_list (
  input  logic                 clk,
  input  logic                 rst_n,
  adll_in_if.sink              in_ch,
  adll_out_if.source           out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // storage
  adll_pkg::payload_t pay_mem  [adll_pkg::Depth];
  adll_pkg::link_t    next_mem [adll_pkg::Depth];
  adll_pkg::link_t    prev_mem [adll_pkg::Depth];

  adll_pkg::payload_t pay_q;
  adll_pkg::link_t    next_q, prev_q;

  // control and list registers
  adll_pkg::state_t   state_r, state_nxt;
  logic [4:0]         slots_r;
  logic [adll_pkg::Depth-1:0] busy_r, busy_nxt;
  adll_pkg::link_t    head_r, head_nxt, tail_r, tail_nxt;
  logic [4:0]         count_r, count_nxt;

  // current item
  adll_pkg::action_t  act_r, act_nxt;
  adll_pkg::idx_t     pos_r, pos_nxt;
  adll_pkg::payload_t data_r, data_nxt;
  adll_pkg::idx_t     nw_r, nw_nxt;
  adll_pkg::status_t  sts_r, sts_nxt;
  adll_pkg::link_t    succ_r, succ_nxt;

  // result register
  logic               ovld_r, ovld_nxt;
  adll_pkg::status_t  osts_r, osts_nxt;
  adll_pkg::idx_t     oslot_r, oslot_nxt;
  adll_pkg::payload_t opay_r, opay_nxt;
  adll_pkg::link_t    onext_r, onext_nxt, oprev_r, oprev_nxt;

  // memory write controls
  logic               pay_we, next_we, prev_we;
  adll_pkg::idx_t     pay_wa, next_wa, prev_wa;
  adll_pkg::link_t    next_wd, prev_wd;

  // free slot search
  logic [4:0]         cap;
  logic               free_ok;
  adll_pkg::idx_t     free_idx;
  logic               in_xfer;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {27'd0, slots_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= 5'd16;
    end else if (psel && penable && pwrite && paddr[2] == adll_pkg::REG_SLOTS_IN_USE) begin
      slots_r <= pwdata[4:0];
    end
  end

  // lowest free slot below the capacity
  always_comb begin
    cap      = (slots_r > 5'd16) ? 5'd16 : slots_r;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = adll_pkg::Depth - 1; i >= 0; i--) begin
      if (!busy_r[i] && 5'(i) < cap) begin
        free_ok  = 1'b1;
        free_idx = adll_pkg::IdxBits'(i);
      end
    end
    if (count_r >= cap) free_ok = 1'b0;
  end

  assign in_ch.ready = (state_r == adll_pkg::ST_IDLE) && !ovld_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // memories: one write port each, registered read at the incoming position
  always_ff @(posedge clk) begin
    if (pay_we)  pay_mem[pay_wa]   <= data_r;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    pay_q  <= pay_mem[in_ch.position];
    next_q <= next_mem[in_ch.position];
    prev_q <= prev_mem[in_ch.position];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    act_nxt   = act_r;
    pos_nxt   = pos_r;
    data_nxt  = data_r;
    nw_nxt    = nw_r;
    sts_nxt   = sts_r;
    succ_nxt  = succ_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    osts_nxt  = osts_r;
    oslot_nxt = oslot_r;
    opay_nxt  = opay_r;
    onext_nxt = onext_r;
    oprev_nxt = oprev_r;
    pay_we  = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    pay_wa  = nw_r;
    next_wa = nw_r;
    prev_wa = nw_r;
    next_wd = succ_r;
    prev_wd = adll_pkg::NoneSlot;

    unique case (state_r)
      adll_pkg::ST_IDLE: begin
        if (in_xfer) begin
          act_nxt  = adll_pkg::action_t'(in_ch.action);
          pos_nxt  = in_ch.position;
          data_nxt = in_ch.payload;
          nw_nxt   = free_idx;
          sts_nxt  = adll_pkg::STS_DONE;
          if (in_ch.action == adll_pkg::ACT_HEAD || in_ch.action == adll_pkg::ACT_AFTER) begin
            if (!free_ok) begin
              sts_nxt = adll_pkg::STS_FULL;
            end else if (in_ch.action == adll_pkg::ACT_AFTER && !busy_r[in_ch.position]) begin
              sts_nxt = adll_pkg::STS_UNUSED;
            end
          end else if (in_ch.action == adll_pkg::ACT_READ && !busy_r[in_ch.position]) begin
            sts_nxt = adll_pkg::STS_UNUSED;
          end
          state_nxt = adll_pkg::ST_EXEC;
        end
      end

      adll_pkg::ST_EXEC: begin
        osts_nxt  = sts_r;
        opay_nxt  = '0;
        onext_nxt = adll_pkg::NoneSlot;
        oprev_nxt = adll_pkg::NoneSlot;
        if ((act_r == adll_pkg::ACT_HEAD || act_r == adll_pkg::ACT_AFTER)
            && sts_r == adll_pkg::STS_DONE) begin
          // new entry: payload and its own links
          pay_we   = 1'b1;
          next_we  = 1'b1;
          prev_we  = 1'b1;
          busy_nxt[nw_r] = 1'b1;
          count_nxt = count_r + 5'd1;
          if (act_r == adll_pkg::ACT_HEAD) begin
            succ_nxt = head_r;
            next_wd  = head_r;
            prev_wd  = adll_pkg::NoneSlot;
            head_nxt = {1'b0, nw_r};
            if (head_r == adll_pkg::NoneSlot) tail_nxt = {1'b0, nw_r};
          end else begin
            succ_nxt = next_q;
            next_wd  = next_q;
            prev_wd  = {1'b0, pos_r};
            if (next_q == adll_pkg::NoneSlot) tail_nxt = {1'b0, nw_r};
          end
          state_nxt = adll_pkg::ST_LINK;
        end else begin
          unique case (sts_r)
            adll_pkg::STS_DONE:   oslot_nxt = (act_r == adll_pkg::ACT_READ) ? pos_r : '0;
            adll_pkg::STS_UNUSED: oslot_nxt = pos_r;
            default:              oslot_nxt = '0;
          endcase
          if (act_r == adll_pkg::ACT_READ && sts_r == adll_pkg::STS_DONE) begin
            opay_nxt  = pay_q;
            onext_nxt = next_q;
            oprev_nxt = prev_q;
          end
          ovld_nxt  = 1'b1;
          state_nxt = adll_pkg::ST_IDLE;
        end
      end

      adll_pkg::ST_LINK: begin
        // splice neighbors onto the new entry
        next_we = (act_r == adll_pkg::ACT_AFTER);
        next_wa = pos_r;
        next_wd = {1'b0, nw_r};
        prev_we = (succ_r != adll_pkg::NoneSlot);
        prev_wa = succ_r[adll_pkg::IdxBits-1:0];
        prev_wd = {1'b0, nw_r};
        oslot_nxt = nw_r;
        ovld_nxt  = 1'b1;
        state_nxt = adll_pkg::ST_IDLE;
      end

      default: state_nxt = adll_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adll_pkg::ST_IDLE;
      busy_r  <= '0;
      head_r  <= adll_pkg::NoneSlot;
      tail_r  <= adll_pkg::NoneSlot;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    pos_r   <= pos_nxt;
    data_r  <= data_nxt;
    nw_r    <= nw_nxt;
    sts_r   <= sts_nxt;
    succ_r  <= succ_nxt;
    osts_r  <= osts_nxt;
    oslot_r <= oslot_nxt;
    opay_r  <= opay_nxt;
    onext_r <= onext_nxt;
    oprev_r <= oprev_nxt;
  end

  // result channel; list registers hold while a result waits
  assign out_ch.valid         = ovld_r;
  assign out_ch.status        = osts_r;
  assign out_ch.slot_used     = oslot_r;
  assign out_ch.element_count = count_r;
  assign out_ch.head_slot     = head_r;
  assign out_ch.tail_slot     = tail_r;
  assign out_ch.read_payload  = opay_r;
  assign out_ch.read_next     = onext_r;
  assign out_ch.read_prev     = oprev_r;

endmodule
